### hdl/websocket_rx_deframer_assert.svh
// Assertion macros shared by the WebSocket receive deframer modules.
`ifndef WEBSOCKET_RX_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_RX_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define WSRX_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define WSRX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wsrx_pkg.sv
// Types, codes and helpers for the WebSocket receive deframer.
`default_nettype none

package wsrx_pkg;

    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_TICK = 1'b1;

    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_PONG      = 3'd2;
    localparam logic [2:0] KIND_CLOSE_REQ = 3'd3;
    localparam logic [2:0] KIND_CLOSED    = 3'd4;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // header byte counts at which each header part is complete, and the mask length
    localparam logic [3:0] NEED_EXT16  = 4'd4;
    localparam logic [3:0] NEED_EXT64  = 4'd10;
    localparam logic [3:0] NEED_SHORT  = 4'd6;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    localparam int HDR_DEPTH = 14;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    typedef enum logic [1:0] {
        LINK_CONNECTED,
        LINK_CLOSING,
        LINK_CLOSED
    } t_link;

    typedef enum logic [2:0] {
        PH_B0,
        PH_B1,
        PH_EXT,
        PH_MASK,
        PH_PAY
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_CLOSED,
        PEND_ECHO
    } t_pend;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [1:0] ftype;
        logic       fin;
        logic       flast;
        logic       rlast;
    } t_result;

    // what one processed item hands to the output sequencer
    typedef struct packed {
        logic       valid;
        t_result    first;
        t_pend      pend;
        logic [3:0] echo_cnt;
        logic       echo_flast;
    } t_desc;

    function automatic t_result mk_res(input logic [2:0] kind, input logic [7:0] value,
                                       input logic [1:0] ftype, input logic fin,
                                       input logic flast, input logic rlast);
        t_result r;
        r.kind     = kind;
        r.out_byte = value;
        r.ftype    = ftype;
        r.fin      = fin;
        r.flast    = flast;
        r.rlast    = rlast;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/websocket_rx_deframer.sv
// WebSocket receive deframer top level: header parse, unmasking, ping echo, close handling.
// An accepted item is registered, and its first result then in the result register.
// Throughput: one item per cycle unless stalled; an item with several results holds the input
// until the rest are out (ping header echo gives 6 to 14, close frame end gives close request
// plus closed if connected). Bursts leave the output sequencer one per cycle unless stalled.
// Reset (synchronous, active low) clears link, parse and count state; timeout goes to 5.
// The 14-byte header store is not cleared; every entry is written before it is read.
`default_nettype none

`include "websocket_rx_deframer_assert.svh"

module websocket_rx_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire        i_opcode,
    input  wire [7:0]  i_rx_byte,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_frame_type,
    output logic       o_fin,
    output logic       o_frame_last,
    output logic       o_run_last,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_wdata
);

    logic                   r_in_valid;
    logic                   r_in_op;
    logic [7:0]             r_in_byte;
    logic [7:0]             r_timeout;

    wsrx_pkg::t_link        r_link;
    wsrx_pkg::t_link        n_link;
    wsrx_pkg::t_phase       r_phase;
    wsrx_pkg::t_phase       n_phase;
    logic [3:0]             r_hcnt;
    logic [3:0]             n_hcnt;
    logic [3:0]             r_need;
    logic [3:0]             n_need;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] n_len;
    logic                   r_ovf;
    logic                   n_ovf;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [LENGTH_BITS-1:0] n_rem;
    logic [7:0]             r_ccnt;
    logic [7:0]             n_ccnt;
    logic [3:0]             r_op;
    logic                   r_fin;
    logic [7:0]             r_key [4];
    logic [7:0]             n_key [4];
    logic [7:0]             r_hdr [wsrx_pkg::HDR_DEPTH];

    logic                   w_can_load;
    logic                   w_proc;
    logic                   w_active;
    logic                   w_byte;
    logic                   w_hdr_we;
    logic [3:0]             w_hdr_idx;
    logic                   w_hdr_done;
    logic [LENGTH_BITS-1:0] w_len_shift;
    logic                   w_ovf_next;
    logic                   w_len_zero;
    logic                   w_last;
    logic                   w_is_data;
    logic                   w_is_ping;
    logic                   w_is_close;
    logic                   w_is_unknown;
    logic [7:0]             w_tick_cnt;
    logic                   w_timeout;
    wsrx_pkg::t_link        w_end_link;
    wsrx_pkg::t_desc        w_end_desc;
    wsrx_pkg::t_desc        w_desc;
    logic [3:0]             w_echo_idx;
    wsrx_pkg::t_result      w_res;

    assign w_proc   = r_in_valid && w_can_load;
    assign o_stall  = r_in_valid && !w_can_load;
    assign w_active = r_link != wsrx_pkg::LINK_CLOSED;
    assign w_byte   = r_in_op == wsrx_pkg::IN_BYTE;

    assign w_hdr_done  = (r_hcnt + 4'd1) >= r_need;
    assign w_len_shift = {r_len[LENGTH_BITS-9:0], r_in_byte};
    // any set bit pushed out of the length register means the length is too large
    assign w_ovf_next  = r_ovf || (r_len[LENGTH_BITS-1 -: 8] != 8'h00);
    assign w_len_zero  = r_len == '0;
    assign w_last      = r_rem == LENGTH_BITS'(1);

    assign w_is_data    = r_op inside {wsrx_pkg::OP_CONT, wsrx_pkg::OP_TEXT, wsrx_pkg::OP_BIN};
    assign w_is_ping    = r_op == wsrx_pkg::OP_PING;
    assign w_is_close   = r_op == wsrx_pkg::OP_CLOSE;
    assign w_is_unknown = !w_is_data && !w_is_ping && !w_is_close;

    assign w_tick_cnt = (r_ccnt == 8'hFF) ? r_ccnt : r_ccnt + 8'd1;
    assign w_timeout  = w_tick_cnt >= r_timeout;

    assign w_hdr_idx = (r_phase == wsrx_pkg::PH_B0) ? 4'd0 : r_hcnt;

    // end of frame: close drops the link, unknown opcodes request a close
    always_comb begin
        w_end_link            = r_link;
        w_end_desc.valid      = 1'b0;
        w_end_desc.first      = wsrx_pkg::mk_res(wsrx_pkg::KIND_CLOSE_REQ, 8'h00, 2'd0,
                                                 1'b0, 1'b0, 1'b1);
        w_end_desc.pend       = wsrx_pkg::PEND_NONE;
        w_end_desc.echo_cnt   = r_need;
        w_end_desc.echo_flast = 1'b0;
        if (w_is_close) begin
            w_end_link       = wsrx_pkg::LINK_CLOSED;
            w_end_desc.valid = 1'b1;
            if (r_link == wsrx_pkg::LINK_CONNECTED) begin
                w_end_desc.first.rlast = 1'b0;
                w_end_desc.pend        = wsrx_pkg::PEND_CLOSED;
            end else begin
                w_end_desc.first.kind = wsrx_pkg::KIND_CLOSED;
            end
        end else if (w_is_unknown) begin
            w_end_link       = wsrx_pkg::LINK_CLOSING;
            w_end_desc.valid = 1'b1;
        end
    end

    // next state of the parser and the link
    always_comb begin
        n_phase = r_phase;
        n_link  = r_link;
        if (w_proc && w_active) begin
            if (!w_byte) begin
                if (r_link == wsrx_pkg::LINK_CLOSING && w_timeout) begin
                    n_link = wsrx_pkg::LINK_CLOSED;
                end
            end else begin
                case (r_phase)
                    wsrx_pkg::PH_B0: n_phase = wsrx_pkg::PH_B1;
                    wsrx_pkg::PH_B1: begin
                        if (!r_in_byte[7]) begin
                            n_link  = wsrx_pkg::LINK_CLOSING;
                            n_phase = wsrx_pkg::PH_B0;
                        end else if (r_in_byte[6:0] == wsrx_pkg::LEN_CODE_16 ||
                                     r_in_byte[6:0] == wsrx_pkg::LEN_CODE_64) begin
                            n_phase = wsrx_pkg::PH_EXT;
                        end else begin
                            n_phase = wsrx_pkg::PH_MASK;
                        end
                    end
                    wsrx_pkg::PH_EXT: begin
                        if (w_hdr_done) begin
                            if (w_ovf_next) begin
                                n_link  = wsrx_pkg::LINK_CLOSING;
                                n_phase = wsrx_pkg::PH_B0;
                            end else begin
                                n_phase = wsrx_pkg::PH_MASK;
                            end
                        end
                    end
                    wsrx_pkg::PH_MASK: begin
                        if (w_hdr_done) begin
                            if (w_len_zero) begin
                                n_link  = w_end_link;
                                n_phase = wsrx_pkg::PH_B0;
                            end else begin
                                n_phase = wsrx_pkg::PH_PAY;
                            end
                        end
                    end
                    wsrx_pkg::PH_PAY: begin
                        if (w_last) begin
                            n_link  = w_end_link;
                            n_phase = wsrx_pkg::PH_B0;
                        end
                    end
                    default: n_phase = wsrx_pkg::PH_B0;
                endcase
            end
        end
    end

    // datapath updates and the result descriptor for the sequencer
    always_comb begin
        n_hcnt            = r_hcnt;
        n_need            = r_need;
        n_len             = r_len;
        n_ovf             = r_ovf;
        n_rem             = r_rem;
        n_ccnt            = r_ccnt;
        n_key             = r_key;
        w_hdr_we          = 1'b0;
        w_desc.valid      = 1'b0;
        w_desc.first      = wsrx_pkg::mk_res(wsrx_pkg::KIND_CLOSE_REQ, 8'h00, 2'd0,
                                             1'b0, 1'b0, 1'b1);
        w_desc.pend       = wsrx_pkg::PEND_NONE;
        w_desc.echo_cnt   = r_need;
        w_desc.echo_flast = w_len_zero;
        if (w_proc && w_active) begin
            if (!w_byte) begin
                if (r_link == wsrx_pkg::LINK_CLOSING) begin
                    n_ccnt = w_tick_cnt;
                    if (w_timeout) begin
                        w_desc.valid      = 1'b1;
                        w_desc.first.kind = wsrx_pkg::KIND_CLOSED;
                    end
                end
            end else begin
                case (r_phase)
                    wsrx_pkg::PH_B0: begin
                        w_hdr_we = 1'b1;
                        n_hcnt   = 4'd1;
                    end
                    wsrx_pkg::PH_B1: begin
                        w_hdr_we = 1'b1;
                        n_hcnt   = r_hcnt + 4'd1;
                        if (!r_in_byte[7]) begin
                            w_desc.valid = 1'b1;
                            n_ccnt       = 8'd0;
                        end else if (r_in_byte[6:0] == wsrx_pkg::LEN_CODE_16) begin
                            n_need = wsrx_pkg::NEED_EXT16;
                            n_len  = '0;
                            n_ovf  = 1'b0;
                        end else if (r_in_byte[6:0] == wsrx_pkg::LEN_CODE_64) begin
                            n_need = wsrx_pkg::NEED_EXT64;
                            n_len  = '0;
                            n_ovf  = 1'b0;
                        end else begin
                            n_need = wsrx_pkg::NEED_SHORT;
                            n_len  = LENGTH_BITS'(r_in_byte[6:0]);
                        end
                    end
                    wsrx_pkg::PH_EXT: begin
                        w_hdr_we = 1'b1;
                        n_hcnt   = r_hcnt + 4'd1;
                        n_len    = w_len_shift;
                        n_ovf    = w_ovf_next;
                        if (w_hdr_done) begin
                            if (w_ovf_next) begin
                                w_desc.valid = 1'b1;
                                n_ccnt       = 8'd0;
                            end else begin
                                n_need = r_need + wsrx_pkg::MASK_BYTES;
                            end
                        end
                    end
                    wsrx_pkg::PH_MASK: begin
                        w_hdr_we = 1'b1;
                        n_hcnt   = r_hcnt + 4'd1;
                        n_key[0] = r_key[1];
                        n_key[1] = r_key[2];
                        n_key[2] = r_key[3];
                        n_key[3] = r_in_byte;
                        if (w_hdr_done) begin
                            n_rem = r_len;
                            if (w_is_ping) begin
                                w_desc.valid = 1'b1;
                                w_desc.first = wsrx_pkg::mk_res(wsrx_pkg::KIND_PONG,
                                                   {r_hdr[0][7:4], wsrx_pkg::OP_PONG},
                                                   2'd0, 1'b0, 1'b0, 1'b0);
                                w_desc.pend  = wsrx_pkg::PEND_ECHO;
                            end else if (w_len_zero) begin
                                if (w_is_data) begin
                                    w_desc.valid = 1'b1;
                                    w_desc.first = wsrx_pkg::mk_res(wsrx_pkg::KIND_EMPTY,
                                                       8'h00, r_op[1:0], r_fin, 1'b1, 1'b1);
                                end else begin
                                    w_desc = w_end_desc;
                                    if (w_is_unknown) begin
                                        n_ccnt = 8'd0;
                                    end
                                end
                            end
                        end
                    end
                    wsrx_pkg::PH_PAY: begin
                        n_rem    = r_rem - LENGTH_BITS'(1);
                        n_key[0] = r_key[1];
                        n_key[1] = r_key[2];
                        n_key[2] = r_key[3];
                        n_key[3] = r_key[0];
                        if (w_is_data) begin
                            w_desc.valid = 1'b1;
                            w_desc.first = wsrx_pkg::mk_res(wsrx_pkg::KIND_DATA,
                                               r_in_byte ^ r_key[0], r_op[1:0], r_fin,
                                               w_last, 1'b1);
                        end else if (w_is_ping) begin
                            w_desc.valid = 1'b1;
                            w_desc.first = wsrx_pkg::mk_res(wsrx_pkg::KIND_PONG, r_in_byte,
                                               2'd0, 1'b0, w_last, 1'b1);
                        end else if (w_last) begin
                            w_desc = w_end_desc;
                            if (w_is_unknown) begin
                                n_ccnt = 8'd0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_timeout  <= wsrx_pkg::TIMEOUT_RESET;
            r_link     <= wsrx_pkg::LINK_CONNECTED;
            r_phase    <= wsrx_pkg::PH_B0;
            r_hcnt     <= 4'd0;
            r_need     <= 4'd0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_rem      <= '0;
            r_ccnt     <= 8'd0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_link  <= n_link;
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_need  <= n_need;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_rem   <= n_rem;
            r_ccnt  <= n_ccnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_rx_byte;
        end
        r_key <= n_key;
        if (w_hdr_we) begin
            r_hdr[w_hdr_idx] <= r_in_byte;
        end
        if (w_hdr_we && r_phase == wsrx_pkg::PH_B0) begin
            r_op  <= r_in_byte[3:0];
            r_fin <= r_in_byte[7];
        end
    end

    wsrx_out_seq u_out_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_proc),
        .i_desc      (w_desc),
        .i_echo_byte (r_hdr[w_echo_idx]),
        .o_echo_idx  (w_echo_idx),
        .i_stall     (i_stall),
        .o_can_load  (w_can_load),
        .o_valid     (o_valid),
        .o_res       (w_res)
    );

    assign o_kind       = w_res.kind;
    assign o_out_byte   = w_res.out_byte;
    assign o_frame_type = w_res.ftype;
    assign o_fin        = w_res.fin;
    assign o_frame_last = w_res.flast;
    assign o_run_last   = w_res.rlast;

    `WSRX_ASSERT_NEXT(a_closed_sticky, r_link == wsrx_pkg::LINK_CLOSED,
                      r_link == wsrx_pkg::LINK_CLOSED, "link left closed state")
    `WSRX_ASSERT_SAME(a_pay_state, r_phase == wsrx_pkg::PH_PAY,
                      (r_rem != '0) && (r_hcnt == r_need), "payload phase with bad counters")

endmodule

`default_nettype wire

### hdl/wsrx_out_seq.sv
// Result register and sequencer for items that give more than one result.
`default_nettype none

`include "websocket_rx_deframer_assert.svh"

module wsrx_out_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wsrx_pkg::t_desc     i_desc,
    input  wire [7:0]           i_echo_byte,
    output logic [3:0]          o_echo_idx,
    input  wire                 i_stall,
    output logic                o_can_load,
    output logic                o_valid,
    output wsrx_pkg::t_result   o_res
);

    logic              r_valid;
    logic              n_valid;
    wsrx_pkg::t_result r_res;
    wsrx_pkg::t_result n_res;
    wsrx_pkg::t_pend   r_pend;
    wsrx_pkg::t_pend   n_pend;
    logic [3:0]        r_idx;
    logic [3:0]        n_idx;
    logic [3:0]        r_cnt;
    logic              r_flast;
    logic              w_free;
    logic              w_echo_end;

    assign w_free     = !r_valid || !i_stall;
    assign o_can_load = w_free && (r_pend == wsrx_pkg::PEND_NONE);
    assign w_echo_end = r_idx == (r_cnt - 4'd1);
    assign o_echo_idx = r_idx;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_comb begin
        n_pend = r_pend;
        if (w_free) begin
            case (r_pend)
                wsrx_pkg::PEND_NONE: begin
                    if (i_load) begin
                        n_pend = i_desc.pend;
                    end
                end
                wsrx_pkg::PEND_CLOSED: n_pend = wsrx_pkg::PEND_NONE;
                wsrx_pkg::PEND_ECHO: begin
                    if (w_echo_end) begin
                        n_pend = wsrx_pkg::PEND_NONE;
                    end
                end
                default: n_pend = wsrx_pkg::PEND_NONE;
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        n_idx   = r_idx;
        if (w_free) begin
            case (r_pend)
                wsrx_pkg::PEND_NONE: begin
                    n_valid = i_load && i_desc.valid;
                    n_res   = i_desc.first;
                    n_idx   = 4'd1;
                end
                wsrx_pkg::PEND_CLOSED: begin
                    n_valid = 1'b1;
                    n_res   = wsrx_pkg::mk_res(wsrx_pkg::KIND_CLOSED, 8'h00, 2'd0,
                                               1'b0, 1'b0, 1'b1);
                end
                wsrx_pkg::PEND_ECHO: begin
                    n_valid = 1'b1;
                    n_res   = wsrx_pkg::mk_res(wsrx_pkg::KIND_PONG, i_echo_byte, 2'd0, 1'b0,
                                               r_flast && w_echo_end, w_echo_end);
                    n_idx   = r_idx + 4'd1;
                end
                default: n_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= wsrx_pkg::PEND_NONE;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_idx <= n_idx;
        if (o_can_load && i_load) begin
            r_cnt   <= i_desc.echo_cnt;
            r_flast <= i_desc.echo_flast;
        end
    end

    `WSRX_ASSERT_SAME(a_pend_holds_result, r_pend != wsrx_pkg::PEND_NONE,
                      r_valid && !r_res.rlast, "pending results behind a run-last result")
    `WSRX_ASSERT_SAME(a_closed_after_req, r_pend == wsrx_pkg::PEND_CLOSED,
                      r_res.kind == wsrx_pkg::KIND_CLOSE_REQ, "closed not after close request")
    `WSRX_ASSERT_SAME(a_echo_is_pong, r_pend == wsrx_pkg::PEND_ECHO,
                      r_res.kind == wsrx_pkg::KIND_PONG, "header echo mixed with other kind")

endmodule

`default_nettype wire

### bench/websocket_rx_deframer_tb.sv
// Self-checking testbench for the WebSocket receive deframer.
`timescale 1ns / 1ps

module websocket_rx_deframer_tb;

    localparam int LEN_BITS       = 64;
    localparam int MAX_BURST      = 14;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    typedef enum int {
        FORM_7,
        FORM_16,
        FORM_64
    } t_len_form;

    typedef enum int {
        END_CLOSE_CONNECTED,
        END_CLOSE_CLOSING,
        END_TIMEOUT
    } t_end;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_opcode    = wsrx_pkg::IN_BYTE;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_stall     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_out_byte;
    logic [1:0] o_frame_type;
    logic       o_fin;
    logic       o_frame_last;
    logic       o_run_last;

    websocket_rx_deframer #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_frame_type(o_frame_type),
        .o_fin       (o_fin),
        .o_frame_last(o_frame_last),
        .o_run_last  (o_run_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // deframer state as seen by the checker
    logic [7:0]          timeout_ticks;
    wsrx_pkg::t_link     link_st;
    wsrx_pkg::t_phase    phase;
    logic [7:0]          hdr_bytes [0:wsrx_pkg::HDR_DEPTH-1];
    int unsigned         hdr_cnt;
    int unsigned         hdr_need;
    logic [63:0]         frame_len;
    logic [63:0]         pay_idx;
    logic [7:0]          close_cnt;
    wsrx_pkg::t_result   burst[$];
    wsrx_pkg::t_result   expected_results[$];

    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    errors         = 0;
    int    items_sent     = 0;
    int    ticks_sent     = 0;
    int    frames_sent    = 0;
    int    results_checked = 0;
    int    quiet_cycles   = 0;
    t_end  end_mode;
    bit    allow_bad;
    string timeout_log;

    function automatic bit is_data_op(input logic [3:0] op);
        return op == wsrx_pkg::OP_CONT || op == wsrx_pkg::OP_TEXT || op == wsrx_pkg::OP_BIN;
    endfunction

    function automatic void add_result(input logic [2:0] kind, input logic [7:0] value,
                                       input logic [1:0] ftype, input logic fin,
                                       input logic flast);
        wsrx_pkg::t_result r;
        if (burst.size() >= MAX_BURST) return;
        r.kind     = kind;
        r.out_byte = value;
        r.ftype    = ftype;
        r.fin      = fin;
        r.flast    = flast;
        r.rlast    = 1'b0;
        burst.push_back(r);
    endfunction

    function automatic void request_close();
        add_result(wsrx_pkg::KIND_CLOSE_REQ, 8'h00, 2'b00, 1'b0, 1'b0);
        link_st   = wsrx_pkg::LINK_CLOSING;
        close_cnt = 8'h00;
    endfunction

    function automatic void store_hdr(input logic [7:0] b);
        if (hdr_cnt < wsrx_pkg::HDR_DEPTH) hdr_bytes[hdr_cnt] = b;
        hdr_cnt++;
    endfunction

    function automatic void finish_frame();
        logic [3:0] op;
        op = hdr_bytes[0][3:0];
        if (op == wsrx_pkg::OP_CLOSE) begin
            if (link_st == wsrx_pkg::LINK_CONNECTED)
                add_result(wsrx_pkg::KIND_CLOSE_REQ, 8'h00, 2'b00, 1'b0, 1'b0);
            add_result(wsrx_pkg::KIND_CLOSED, 8'h00, 2'b00, 1'b0, 1'b0);
            link_st = wsrx_pkg::LINK_CLOSED;
        end else if (!is_data_op(op) && op != wsrx_pkg::OP_PING) begin
            request_close();
        end
        phase = wsrx_pkg::PH_B0;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [63:0] len;
        logic [3:0]  op;
        logic        fin;
        logic [7:0]  echo;
        logic        at_end;
        int unsigned i;
        int unsigned kidx;
        op  = hdr_bytes[0][3:0];
        fin = hdr_bytes[0][7];
        case (phase)
            wsrx_pkg::PH_B0: begin
                hdr_cnt = 0;
                store_hdr(b);
                phase = wsrx_pkg::PH_B1;
            end
            wsrx_pkg::PH_B1: begin
                store_hdr(b);
                if (!b[7]) begin
                    request_close();
                    phase = wsrx_pkg::PH_B0;
                end else if (b[6:0] == wsrx_pkg::LEN_CODE_16) begin
                    hdr_need = wsrx_pkg::NEED_EXT16;
                    phase    = wsrx_pkg::PH_EXT;
                end else if (b[6:0] == wsrx_pkg::LEN_CODE_64) begin
                    hdr_need = wsrx_pkg::NEED_EXT64;
                    phase    = wsrx_pkg::PH_EXT;
                end else begin
                    frame_len = 64'(b[6:0]);
                    hdr_need  = wsrx_pkg::NEED_SHORT;
                    phase     = wsrx_pkg::PH_MASK;
                end
            end
            wsrx_pkg::PH_EXT: begin
                store_hdr(b);
                if (hdr_cnt >= hdr_need) begin
                    len = '0;
                    for (i = 2; i < hdr_need && i < wsrx_pkg::HDR_DEPTH; i++)
                        len = {len[55:0], hdr_bytes[i]};
                    if (LEN_BITS < 64 && (len >> (LEN_BITS % 64)) != 0) begin
                        request_close();
                        phase = wsrx_pkg::PH_B0;
                    end else begin
                        frame_len = len;
                        hdr_need  = hdr_need + wsrx_pkg::MASK_BYTES;
                        phase     = wsrx_pkg::PH_MASK;
                    end
                end
            end
            wsrx_pkg::PH_MASK: begin
                store_hdr(b);
                if (hdr_cnt >= hdr_need) begin
                    pay_idx = '0;
                    if (is_data_op(op)) begin
                        if (frame_len == 0)
                            add_result(wsrx_pkg::KIND_EMPTY, 8'h00, op[1:0], fin, 1'b1);
                    end else if (op == wsrx_pkg::OP_PING) begin
                        // header echoed back with the opcode turned into a pong
                        for (i = 0; i < hdr_cnt && i < wsrx_pkg::HDR_DEPTH; i++) begin
                            echo = hdr_bytes[i];
                            if (i == 0) echo[3:0] = wsrx_pkg::OP_PONG;
                            add_result(wsrx_pkg::KIND_PONG, echo, 2'b00, 1'b0,
                                       frame_len == 0 && i + 1 == hdr_cnt);
                        end
                    end
                    if (frame_len == 0) finish_frame();
                    else phase = wsrx_pkg::PH_PAY;
                end
            end
            wsrx_pkg::PH_PAY: begin
                at_end = (pay_idx + 64'd1) == frame_len;
                kidx   = (hdr_cnt - wsrx_pkg::MASK_BYTES + 32'(pay_idx[1:0]))
                         % wsrx_pkg::HDR_DEPTH;
                if (is_data_op(op))
                    add_result(wsrx_pkg::KIND_DATA, b ^ hdr_bytes[kidx], op[1:0], fin,
                               at_end);
                else if (op == wsrx_pkg::OP_PING)
                    add_result(wsrx_pkg::KIND_PONG, b, 2'b00, 1'b0, at_end);
                pay_idx++;
                if (at_end) finish_frame();
            end
            default: phase = wsrx_pkg::PH_B0;
        endcase
    endfunction

    function automatic void deframe_item(input logic op, input logic [7:0] b);
        wsrx_pkg::t_result r;
        burst.delete();
        if (link_st == wsrx_pkg::LINK_CLOSED) return;
        if (op == wsrx_pkg::IN_TICK) begin
            if (link_st == wsrx_pkg::LINK_CLOSING) begin
                if (close_cnt != 8'hFF) close_cnt++;
                if (close_cnt >= timeout_ticks) begin
                    add_result(wsrx_pkg::KIND_CLOSED, 8'h00, 2'b00, 1'b0, 1'b0);
                    link_st = wsrx_pkg::LINK_CLOSED;
                end
            end
        end else begin
            take_byte(b);
        end
        if (burst.size() > 0) begin
            r = burst.pop_back();
            r.rlast = 1'b1;
            burst.push_back(r);
        end
        foreach (burst[k]) expected_results.push_back(burst[k]);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (errors < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    // one transaction in; the expectation is formed at the accepting edge
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        deframe_item(op, b);
        items_sent++;
        if (op == wsrx_pkg::IN_TICK) ticks_sent++;
        @(negedge i_clk);
    endtask

    // ticks that would drop the link are held back until the final test
    task automatic maybe_tick(input int pct);
        if (pct > 0 && $urandom_range(0, 99) < pct && link_st != wsrx_pkg::LINK_CLOSED &&
            !(link_st == wsrx_pkg::LINK_CLOSING &&
              int'(close_cnt) + 1 >= int'(timeout_ticks)))
            send_item(wsrx_pkg::IN_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] b0, input t_len_form form,
                              input logic [31:0] key, input logic [7:0] pay[$],
                              input int tick_pct);
        logic [7:0]  hdr[$];
        logic [63:0] len;
        len = 64'(pay.size());
        hdr.push_back(b0);
        case (form)
            FORM_16: begin
                hdr.push_back({1'b1, wsrx_pkg::LEN_CODE_16});
                hdr.push_back(len[15:8]);
                hdr.push_back(len[7:0]);
            end
            FORM_64: begin
                hdr.push_back({1'b1, wsrx_pkg::LEN_CODE_64});
                for (int k = 7; k >= 0; k--) hdr.push_back(len[8*k +: 8]);
            end
            default: hdr.push_back({1'b1, len[6:0]});
        endcase
        for (int k = 3; k >= 0; k--) hdr.push_back(key[8*k +: 8]);
        foreach (hdr[k]) begin
            maybe_tick(tick_pct);
            send_item(wsrx_pkg::IN_BYTE, hdr[k]);
        end
        foreach (pay[k]) begin
            maybe_tick(tick_pct);
            send_item(wsrx_pkg::IN_BYTE, pay[k]);
        end
        frames_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_timeout(input logic [7:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        timeout_ticks = value;
        timeout_log   = {timeout_log, $sformatf(" %0d", value)};
    endtask

    task automatic test_data_frames();
        logic [7:0] pay[$];
        // all-ones key: 0xFF unmasks to 0x00 and back
        pay.push_back(8'hFF);
        pay.push_back(8'h00);
        send_frame({1'b1, 3'b000, wsrx_pkg::OP_TEXT}, FORM_7, 32'hFFFF_FFFF, pay, 0);
        pay.delete();
        // empty binary fragment with reserved bits set, 16-bit length form
        send_frame({1'b0, 3'b111, wsrx_pkg::OP_BIN}, FORM_16, 32'h0000_0000, pay, 0);
    endtask

    task automatic test_ping_echo();
        logic [7:0] pay[$];
        send_frame({1'b1, 3'b000, wsrx_pkg::OP_PING}, FORM_7, 32'hA5C3_0F81, pay, 0);
    endtask

    task automatic test_tick_connected();
        send_item(wsrx_pkg::IN_TICK, 8'hFF);
    endtask

    task automatic test_bad_frames();
        logic [7:0] pay[$];
        // mask bit clear: close request right at the length byte
        send_item(wsrx_pkg::IN_BYTE, {1'b1, 3'b000, wsrx_pkg::OP_BIN});
        send_item(wsrx_pkg::IN_BYTE, {1'b0, wsrx_pkg::LEN_CODE_64});
        send_item(wsrx_pkg::IN_TICK, 8'h00);
        // unsolicited pong counts as an unknown opcode
        send_frame({1'b1, 3'b000, wsrx_pkg::OP_PONG}, FORM_7, 32'h1234_5678, pay, 0);
    endtask

    task automatic run_random_phase(input int n_items, input int send_pct, input int stall_pct);
        logic [7:0] pay[$];
        logic [7:0] b0;
        logic [3:0] op;
        t_len_form  form;
        int         n;
        int         roll;
        int         first;
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(0, 99) < 3) wait_drained();
            roll = $urandom_range(0, 99);
            if (allow_bad && roll >= 90) begin
                maybe_tick(6);
                send_item(wsrx_pkg::IN_BYTE, 8'($urandom));
                maybe_tick(6);
                send_item(wsrx_pkg::IN_BYTE, {1'b0, 7'($urandom)});
                frames_sent++;
                continue;
            end
            if (allow_bad && roll >= 78) begin
                do op = 4'($urandom);
                while (is_data_op(op) || op == wsrx_pkg::OP_CLOSE || op == wsrx_pkg::OP_PING);
            end else if (roll < 62) begin
                case ($urandom_range(0, 2))
                    0: op = wsrx_pkg::OP_CONT;
                    1: op = wsrx_pkg::OP_TEXT;
                    default: op = wsrx_pkg::OP_BIN;
                endcase
            end else begin
                op = wsrx_pkg::OP_PING;
            end
            b0 = {4'($urandom), op};
            roll = $urandom_range(0, 99);
            form = (roll < 70) ? FORM_7 : (roll < 85) ? FORM_16 : FORM_64;
            roll = $urandom_range(0, 99);
            if (roll < 20) n = 0;
            else if (roll < 88) n = $urandom_range(1, 12);
            else if (roll < 97) n = $urandom_range(13, 40);
            else n = (form == FORM_7) ? 125 : $urandom_range(126, 300);
            pay.delete();
            repeat (n) pay.push_back(8'($urandom));
            send_frame(b0, form, 32'($urandom), pay, 6);
        end
    endtask

    task automatic test_link_close();
        logic [7:0] pay[$];
        if (end_mode == END_TIMEOUT) begin
            set_timeout(8'($urandom_range(1, 6)));
            while (link_st != wsrx_pkg::LINK_CLOSED)
                send_item(wsrx_pkg::IN_TICK, 8'($urandom));
        end else begin
            // close payload is swallowed without results
            repeat ($urandom_range(0, 3)) pay.push_back(8'($urandom));
            send_frame({1'b1, 3'b000, wsrx_pkg::OP_CLOSE}, FORM_7, 32'($urandom), pay, 0);
        end
        // link is down: everything from here on is dropped
        repeat (6) send_item(1'($urandom), 8'($urandom));
    endtask

    always @(negedge i_clk) i_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge i_clk) begin : check_results
        wsrx_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                        o_kind, o_out_byte));
            end else begin
                want = expected_results.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.out_byte ||
                    o_frame_type !== want.ftype || o_fin !== want.fin ||
                    o_frame_last !== want.flast || o_run_last !== want.rlast)
                    flag_mismatch($sformatf(
                        "result %0d got k%0d b%02h t%0d f%b l%b r%b want k%0d b%02h t%0d f%b l%b r%b",
                        results_checked, o_kind, o_out_byte, o_frame_type, o_fin,
                        o_frame_last, o_run_last, want.kind, want.out_byte, want.ftype,
                        want.fin, want.flast, want.rlast));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        timeout_ticks = wsrx_pkg::TIMEOUT_RESET;
        link_st       = wsrx_pkg::LINK_CONNECTED;
        phase         = wsrx_pkg::PH_B0;
        hdr_cnt       = 0;
        hdr_need      = 0;
        frame_len     = '0;
        pay_idx       = '0;
        close_cnt     = 8'h00;
        timeout_log   = " 5";
        end_mode      = t_end'($urandom_range(0, 2));
        allow_bad     = (end_mode != END_CLOSE_CONNECTED);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_data_frames();
        test_ping_echo();
        test_tick_connected();
        run_random_phase(80, 0, 0);
        if (allow_bad) test_bad_frames();
        set_timeout(8'd1);
        run_random_phase(80, 87, 0);
        set_timeout(8'd255);
        run_random_phase(80, 0, 87);
        set_timeout(8'($urandom_range(2, 254)));
        run_random_phase(80, 29, 29);
        test_link_close();
        wait_drained();

        $display("Sent %0d items (%0d ticks, %0d frames), checked %0d results, %0d errors",
                 items_sent, ticks_sent, frames_sent, results_checked, errors);
        $display("Closing timeouts used:%s; link taken down by %s",
                 timeout_log, end_mode.name());
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
